FILE: src/binary_max_heap_queue_core_macros.svh
// Assertion helpers for the heap queue checker.
`ifndef BINARY_MAX_HEAP_QUEUE_CORE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_CORE_MACROS_SVH
// Implication checked every cycle outside reset.
`define BMHQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbl failed");
// Next-cycle implication checked outside reset.
`define BMHQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbl failed");
`endif

FILE: src/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types and constants shared by the heap queue modules.
// ----------------------------------------------------------------------------
package bmhq_pkg;
    localparam int unsigned CAPACITY  = 1024;
    localparam int unsigned KEY_WIDTH = 32;
    localparam int unsigned ADDR_W    = $clog2(CAPACITY);
    localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_WIDTH-1:0] t_key;
    typedef logic [ADDR_W-1:0]           t_addr;
    typedef logic [CNT_W-1:0]            t_cnt;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_POS = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_POS,     // read entry at position (update) or root, then last (delete)
        S_CHK,        // data of entry back, decide direction
        S_UP_RD,      // read parent
        S_UP_CMP,
        S_DN_RD_R,    // read right child
        S_DN_RD_L,    // read left child, right data back
        S_DN_CMP,     // left data back
        S_DONE
    } t_state;

    // memory port request from sequencer
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_key  wdata;
        t_addr raddr;
    } t_mem_req;

    // 1-based position to 0-based memory address
    function automatic t_addr pos2addr(input t_cnt p);
        t_cnt d;
        d = p - t_cnt'(1);
        return d[ADDR_W-1:0];
    endfunction
endpackage

FILE: src/binary_max_heap_queue_core.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue_core
// Max-priority queue kept as a 1-based binary heap in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  request | i_valid / o_stall  | i_req_type, i_key_value, i_position
//  result  | o_valid / i_stall  | o_removed_max, o_status, o_count_after
//
//  One request at a time. A rejected request goes to S_DONE and then to the
//  output register. A sift walks one level at a time over the single RAM read
//  port, after a read of the entry for an update or of the root and the last
//  entry for a delete.
//  Reset clears state, count and output valid; RAM contents are never used before written.
//  The result sits in an output register; a new request is accepted only when
//  no result waits or the waiting one is taken in the same cycle.
module binary_max_heap_queue_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_req_type,
    input  logic signed [31:0]       i_key_value,
    input  logic [10:0]              i_position,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [31:0]       o_removed_max,
    output logic [1:0]               o_status,
    output logic [10:0]              o_count_after
);
    import bmhq_pkg::*;

    t_mem_req w_mem;
    t_key     w_rdata;
    logic     w_busy, w_done, w_start;
    t_key     w_removed;
    t_status  w_status;
    t_cnt     w_count;
    logic     r_valid;

    // sequencer leaves S_DONE without waiting, so the output register must
    // be free (or freeing) before a request is started
    assign o_stall = w_busy || (r_valid && i_stall);
    assign w_start = i_valid && !o_stall;

    bmhq_ram #(.DEPTH(CAPACITY), .WIDTH(KEY_WIDTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    bmhq_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_req     (t_req'(i_req_type)),
        .i_key     (t_key'(i_key_value)),
        .i_pos     (t_cnt'(i_position)),
        .i_rdata   (w_rdata),
        .o_mem     (w_mem),
        .o_busy    (w_busy),
        .o_done    (w_done),
        .o_removed (w_removed),
        .o_status  (w_status),
        .o_count   (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_done) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (w_done) begin
            o_removed_max <= w_removed;
            o_status      <= w_status;
            o_count_after <= w_count;
        end
    end
    assign o_valid = r_valid;
endmodule

FILE: src/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Single-port-write, single-port-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: src/bmhq_seq.sv
// ----------------------------------------------------------------------------
// bmhq_seq
// Sift sequencer: walks the heap one level at a time over the RAM.
// ----------------------------------------------------------------------------
module bmhq_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bmhq_pkg::t_req     i_req,
    input  bmhq_pkg::t_key     i_key,
    input  bmhq_pkg::t_cnt     i_pos,
    input  bmhq_pkg::t_key     i_rdata,
    output bmhq_pkg::t_mem_req o_mem,
    output logic               o_busy,
    output logic               o_done,
    output bmhq_pkg::t_key     o_removed,
    output bmhq_pkg::t_status  o_status,
    output bmhq_pkg::t_cnt     o_count
);
    import bmhq_pkg::*;

    t_state  r_state, n_state;
    t_cnt    r_count, n_count;
    t_cnt    r_p, n_p;          // current 1-based position of moving key
    t_key    r_key, n_key;      // moving key
    t_key    r_rkey, n_rkey;    // right child key
    t_key    r_removed, n_removed;
    t_status r_status, n_status;
    t_req    r_req, n_req;
    logic    r_first, n_first;  // delete: first read gives root

    logic [CNT_W:0] w_l, w_r;
    t_cnt           w_par;
    logic           w_has_l, w_has_r;

    assign w_l     = {r_p, 1'b0};
    assign w_r     = {r_p, 1'b1};
    assign w_par   = r_p >> 1;
    assign w_has_l = w_l <= {1'b0, r_count};
    assign w_has_r = w_r <= {1'b0, r_count};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_p       = r_p;
        n_key     = r_key;
        n_rkey    = r_rkey;
        n_removed = r_removed;
        n_status  = r_status;
        n_req     = r_req;
        n_first   = r_first;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req     = i_req;
                    n_removed = '0;
                    n_status  = ST_OK;
                    n_key     = i_key;
                    n_state   = S_DONE;
                    case (i_req)
                        REQ_INSERT: begin
                            if (r_count >= t_cnt'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + t_cnt'(1);
                                n_p     = r_count + t_cnt'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        REQ_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_p     = t_cnt'(1);
                                n_first = 1'b1;
                                n_state = S_RD_POS;
                            end
                        end
                        REQ_UPDATE: begin
                            if (i_pos == '0 || i_pos > r_count) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                n_p     = i_pos;
                                n_state = S_RD_POS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_POS: n_state = S_CHK;
            S_CHK: begin
                if (r_req == REQ_DELETE) begin
                    if (r_first) begin
                        n_removed = i_rdata;
                        n_first   = 1'b0;
                        n_state   = S_RD_POS;   // now read last entry
                    end else begin
                        n_key   = i_rdata;
                        n_count = r_count - t_cnt'(1);
                        n_state = S_DN_RD_R;
                    end
                end else if (i_rdata > r_key) begin
                    n_state = S_DN_RD_R;
                end else if (i_rdata < r_key) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UP_RD: n_state = (r_p > t_cnt'(1)) ? S_UP_CMP : S_DONE;
            S_UP_CMP: begin
                if (i_rdata < r_key) begin
                    n_p     = w_par;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_RD_R: n_state = w_has_l ? S_DN_RD_L : S_DONE;
            S_DN_RD_L: begin
                n_rkey  = i_rdata;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (w_has_r && r_rkey > r_key && !(w_has_l && i_rdata > r_rkey)) begin
                    n_p     = w_r[CNT_W-1:0];
                    n_state = S_DN_RD_R;
                end else if (w_has_l && i_rdata > r_key
                             && !(w_has_r && r_rkey >= i_rdata)) begin
                    n_p     = w_l[CNT_W-1:0];
                    n_state = S_DN_RD_R;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory traffic: the moving key is always written at r_p before the
    // step that moves it, so a swap is one write of the other key.
    always_comb begin
        o_mem       = '0;
        o_mem.waddr = pos2addr(r_p);
        o_mem.wdata = r_key;
        o_mem.raddr = pos2addr(r_p);
        case (r_state)
            S_RD_POS: begin
                if (r_req == REQ_DELETE && !r_first) begin
                    o_mem.raddr = pos2addr(r_count);
                end
            end
            S_UP_RD: begin
                o_mem.we    = 1'b1;
                o_mem.raddr = pos2addr(w_par);
            end
            S_UP_CMP: begin
                if (i_rdata < r_key) begin
                    o_mem.we    = 1'b1;
                    o_mem.wdata = i_rdata;
                end
            end
            S_DN_RD_R: begin
                o_mem.we    = 1'b1;
                o_mem.raddr = pos2addr(w_r[CNT_W-1:0]);
            end
            S_DN_RD_L: o_mem.raddr = pos2addr(w_l[CNT_W-1:0]);
            S_DN_CMP: begin
                if (w_has_r && r_rkey > r_key && !(w_has_l && i_rdata > r_rkey)) begin
                    o_mem.we    = 1'b1;
                    o_mem.wdata = r_rkey;
                end else if (w_has_l && i_rdata > r_key
                             && !(w_has_r && r_rkey >= i_rdata)) begin
                    o_mem.we    = 1'b1;
                    o_mem.wdata = i_rdata;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_p       <= n_p;
        r_key     <= n_key;
        r_rkey    <= n_rkey;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_req     <= n_req;
        r_first   <= n_first;
    end

    assign o_busy    = r_state != S_IDLE;
    assign o_done    = r_state == S_DONE;
    assign o_removed = r_removed;
    assign o_status  = r_status;
    assign o_count   = r_count;
endmodule

FILE: src/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks for binary_max_heap_queue_core.
// ----------------------------------------------------------------------------
`include "binary_max_heap_queue_core_macros.svh"
module bmhq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [10:0] o_count_after
);
    import bmhq_pkg::*;

    `BMHQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_count_after))
    `BMHQ_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, o_valid, o_count_after <= 11'(CAPACITY))
    `BMHQ_ASSERT_IMP(a_full_cnt, i_clk, i_rst_n, o_valid && o_status == ST_FULL, o_count_after == 11'(CAPACITY))
    `BMHQ_ASSERT_IMP(a_empty_cnt, i_clk, i_rst_n, o_valid && o_status == ST_EMPTY, o_count_after == '0)
    `BMHQ_ASSERT_NXT(a_one_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
endmodule

bind binary_max_heap_queue_core bmhq_checker u_bmhq_checker (.*);

FILE: tb/binary_max_heap_queue_core_test.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue_core_test
// Drives insert, delete-max, update and ignored-type requests into the heap queue and checks
// every result against a behavioral heap model kept inside the bench.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bmhq_pkg::*;

    localparam int HEAP_CAP    = 1024;
    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE_CYC  = 60;

    typedef struct {
        logic signed [31:0] removed;
        logic [1:0]         status;
        logic [10:0]        count;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_req_type;
    logic signed [31:0] i_key_value;
    logic [10:0]        i_position;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_removed_max;
    logic [1:0]         o_status;
    logic [10:0]        o_count_after;

    binary_max_heap_queue_core DUT (.*);

    // Behavioral heap, 1-based
    logic signed [31:0] model_heap [1:HEAP_CAP];
    int                 model_count;
    t_result            pending_results [$];

    int  fail_count;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void heap_swap(int a, int b);
        logic signed [31:0] t;
        t = model_heap[a];
        model_heap[a] = model_heap[b];
        model_heap[b] = t;
    endfunction

    function automatic void heap_raise(int p);
        while (p > 1 && model_heap[p / 2] < model_heap[p]) begin
            heap_swap(p / 2, p);
            p = p / 2;
        end
    endfunction

    // Right child wins on a tie: it is checked first and the left needs strictly more.
    function automatic void heap_lower(int p);
        int l;
        int r;
        int big;
        forever begin
            l = 2 * p;
            r = 2 * p + 1;
            big = p;
            if (r <= model_count && model_heap[r] > model_heap[big]) big = r;
            if (l <= model_count && model_heap[l] > model_heap[big]) big = l;
            if (big == p) return;
            heap_swap(p, big);
            p = big;
        end
    endfunction

    function automatic t_result heap_apply(logic [1:0] req, logic signed [31:0] key,
                                           logic [10:0] pos);
        t_result res;
        res.removed = '0;
        res.status  = ST_OK;
        case (t_req'(req))
            REQ_INSERT: begin
                if (model_count >= HEAP_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    model_count++;
                    model_heap[model_count] = key;
                    heap_raise(model_count);
                end
            end
            REQ_DELETE: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.removed = model_heap[1];
                    model_heap[1] = model_heap[model_count];
                    model_count--;
                    heap_lower(1);
                end
            end
            REQ_UPDATE: begin
                if (pos < 1 || pos > model_count) begin
                    res.status = ST_BAD_POS;
                end else if (model_heap[pos] > key) begin
                    model_heap[pos] = key;
                    heap_lower(pos);
                end else if (model_heap[pos] < key) begin
                    model_heap[pos] = key;
                    heap_raise(pos);
                end
            end
            default: ;
        endcase
        res.count = model_count[10:0];
        return res;
    endfunction

    // Result checker; also drives the receiver stall.
    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_removed_max !== exp_res.removed) begin
                        $error("removed_max expected %0d got %0d", exp_res.removed,
                               o_removed_max);
                        fail_count++;
                    end
                    if (o_status !== exp_res.status) begin
                        $error("status expected %0d got %0d", exp_res.status, o_status);
                        fail_count++;
                    end
                    if (o_count_after !== exp_res.count) begin
                        $error("count_after expected %0d got %0d", exp_res.count,
                               o_count_after);
                        fail_count++;
                    end
                end
            end
            i_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on handshake inactivity
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one request; the model is updated at the accepting edge.
    // Valid stays up after acceptance; drain drops it, the next send drops it or puts up its request.
    task automatic send_request(logic [1:0] req, logic signed [31:0] key, logic [10:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_key_value <= key;
        i_position  <= pos;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(heap_apply(req, key, pos));
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return $signed(32'($urandom_range(7))) - 32'sd3;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic test_directed;
        send_request(REQ_DELETE, 32'sd5, 11'd0);              // delete when empty
        send_request(REQ_UPDATE, 32'sd5, 11'd1);              // update, empty heap
        send_request(REQ_INSERT, 32'sh8000_0000, 11'h7ff);
        send_request(REQ_INSERT, 32'sh7fff_ffff, 11'd0);
        send_request(REQ_INSERT, 32'sd7, 11'd0);
        send_request(REQ_INSERT, 32'sd7, 11'd0);              // equal children
        send_request(REQ_INSERT, -32'sd1, 11'd0);
        send_request(REQ_UPDATE, 32'sd0, 11'd0);              // position zero
        send_request(REQ_UPDATE, 32'sd0, 11'd6);              // past count
        send_request(REQ_UPDATE, 32'sh7fff_ffff, 11'h7ff);
        send_request(REQ_UPDATE, 32'sd7, 11'd3);              // equal key, no move
        send_request(REQ_UPDATE, 32'sh7fff_fff0, 11'd5);      // raise
        send_request(REQ_UPDATE, 32'sh8000_0000, 11'd1);      // lower root
        send_request(REQ_NONE, 32'sd1, 11'd1);                // ignored type
        repeat (6) send_request(REQ_DELETE, 32'sd0, 11'd0);
        drain();
    endtask

    // Mostly valid traffic with a drift toward inserts or deletes.
    task automatic test_random(int n, int ins_pct);
        int r;
        int pos;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if ($urandom_range(19) == 0) pos = $urandom_range(2047);
            else pos = (model_count == 0) ? 1 : $urandom_range(model_count, 1);
            if (r < ins_pct) send_request(REQ_INSERT, rand_key(), 11'($urandom));
            else if (r < ins_pct + (100 - ins_pct) / 2)
                send_request(REQ_DELETE, rand_key(), 11'($urandom));
            else if (r < 98) send_request(REQ_UPDATE, rand_key(), 11'(pos));
            else send_request(REQ_NONE, rand_key(), 11'($urandom));
        end
        drain();
    endtask

    // Fill to capacity with inserts, the receiver holding off at first; then probe the full heap.
    task automatic test_fill_and_backpressure;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        while (model_count < HEAP_CAP) send_request(REQ_INSERT, rand_key(), 11'd0);
        send_request(REQ_INSERT, 32'sd1, 11'd0);              // full
        send_request(REQ_UPDATE, 32'sd3, 11'd1024);           // last position
        send_request(REQ_UPDATE, 32'sd3, 11'd1025);
        drain();
    endtask

    initial begin
        fail_count     = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        model_count    = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_req_type  = REQ_NONE;
        i_key_value = '0;
        i_position  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(20, 60);
        send_idle_pct = 50;
        test_random(20, 50);
        send_idle_pct = 0; recv_stall_pct = 50;
        test_random(20, 40);
        send_idle_pct = 15; recv_stall_pct = 15;
        test_random(20, 55);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_fill_and_backpressure();
        send_idle_pct = 15; recv_stall_pct = 15;
        test_random(30, 45);

        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
